@@ sv/crf_pkg.sv @@
// Shared types, field widths and operation codes for the copy request ring.
package crf_pkg;

   localparam int OWNER_W     = 8;
   localparam int ADDR_W      = 39;
   localparam int LEN_W       = 31;
   localparam int RANGE_W     = ADDR_W + 1;
   localparam int REQ_TDATA_W = 120;
   localparam int RSP_TDATA_W = 128;
   localparam int RING_DEPTH_DEF = 8;

   typedef enum logic [1:0] {
      KIND_SUBMIT   = 2'd0,
      KIND_PEEK     = 2'd1,
      KIND_COMPLETE = 2'd2,
      KIND_SYNC     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_NONE = 2'd0,
      STATUS_OK   = 2'd1,
      STATUS_FAIL = 2'd2
   } status_type;

   // Request payload as it sits in req_tdata, last field in the low bits.
   typedef struct packed {
      logic               task_ok;
      logic [LEN_W-1:0]   length;
      logic [ADDR_W-1:0]  dst_addr;
      logic [ADDR_W-1:0]  src_addr;
      logic [OWNER_W-1:0] owner;
   } req_type;

   // One stored copy descriptor.
   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [LEN_W-1:0]   length;
      logic [ADDR_W-1:0]  dst_addr;
      logic [ADDR_W-1:0]  src_addr;
   } entry_type;

   // Fence query held for the duration of a sync scan.
   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [ADDR_W-1:0]  base;
      logic [RANGE_W-1:0] limit;
   } query_type;

   // Result payload as it sits in rsp_tdata, last field in the low bits.
   typedef struct packed {
      logic               pending;
      status_type         done_status;
      logic [OWNER_W-1:0] head_owner;
      logic [LEN_W-1:0]   head_length;
      logic [ADDR_W-1:0]  head_dst;
      logic [ADDR_W-1:0]  head_src;
      logic               queue_empty;
      logic               accepted;
   } rsp_type;

endpackage

@@ sv/copy_request_ring_with_fence_top.sv @@
// Copy descriptor ring with a fence query that scans the pending entries.
// Sync reads one entry a cycle through the descriptor RAM read port.
// One request is worked on at a time and the next is accepted in the cycle after
// its result is loaded; a result still held by rsp_tready delays that load.
// Reset empties the ring.
module copy_request_ring_with_fence_top #(
   parameter int RING_DEPTH = crf_pkg::RING_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // owner, src_addr, dst_addr, length, task_ok; zero padded
   input  logic [crf_pkg::REQ_TDATA_W-1:0] req_tdata,
   // kind
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // accepted, queue_empty, head_src, head_dst, head_length, head_owner,
   // done_status, pending; zero padded
   output logic [crf_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import crf_pkg::*;

   localparam int IDX_W = $clog2(RING_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PEEK,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   kind_type         kind_ff, kind_in;
   req_type          req_ff, req_in;
   query_type        query_ff, query_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             hit_ff, hit_in;
   rsp_type          res_ff, res_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   req_type          req_word;
   entry_type        wr_entry;
   entry_type        rd_entry;
   logic [$bits(entry_type)-1:0] rd_word;
   logic             wr_en;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             entry_hit;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      if (idx == IDX_W'(RING_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + 1'b1;
      end
      return nxt;
   endfunction

   assign req_word = req_type'(req_tdata[$bits(req_type)-1:0]);

   assign wr_entry.owner    = req_ff.owner;
   assign wr_entry.length   = req_ff.length;
   assign wr_entry.dst_addr = req_ff.dst_addr;
   assign wr_entry.src_addr = req_ff.src_addr;

   crf_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (RING_DEPTH)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry = entry_type'(rd_word);

   crf_match u_match (
      .entry (rd_entry),
      .query (query_ff),
      .hit   (entry_hit)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-$bits(rsp_type)){1'b0}}, rsp_data_ff};

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      req_in        = req_ff;
      query_in      = query_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      scan_in       = scan_ff;
      rd_pend_in    = rd_pend_ff;
      hit_in        = hit_ff;
      res_in        = res_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in        = kind_type'(req_tuser);
               req_in         = req_word;
               query_in.owner = req_word.owner;
               query_in.base  = req_word.dst_addr;
               query_in.limit = {1'b0, req_word.dst_addr}
                              + {{(RANGE_W-LEN_W){1'b0}}, req_word.length};
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in   = '0;
            state_in = ST_DONE;
            unique case (kind_ff)
               KIND_SUBMIT: begin
                  if (ring_next(tail_ff) != head_ff) begin
                     wr_en           = 1'b1;
                     tail_in         = ring_next(tail_ff);
                     res_in.accepted = 1'b1;
                  end else begin
                     res_in.queue_empty = head_ff == tail_ff;
                  end
               end
               KIND_PEEK: begin
                  if (head_ff == tail_ff) begin
                     res_in.queue_empty = 1'b1;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     state_in = ST_PEEK;
                  end
               end
               KIND_COMPLETE: begin
                  if (head_ff == tail_ff) begin
                     res_in.queue_empty = 1'b1;
                  end else begin
                     head_in            = ring_next(head_ff);
                     res_in.done_status = req_ff.task_ok ? STATUS_OK : STATUS_FAIL;
                     res_in.queue_empty = ring_next(head_ff) == tail_ff;
                  end
               end
               KIND_SYNC: begin
                  scan_in    = head_ff;
                  rd_pend_in = 1'b0;
                  hit_in     = 1'b0;
                  state_in   = ST_SCAN;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_PEEK: begin
            res_in.head_src    = rd_entry.src_addr;
            res_in.head_dst    = rd_entry.dst_addr;
            res_in.head_length = rd_entry.length;
            res_in.head_owner  = rd_entry.owner;
            state_in           = ST_DONE;
         end
         ST_SCAN: begin
            // One read is issued per cycle; its data is compared in the next cycle.
            if (rd_pend_ff && entry_hit) begin
               hit_in = 1'b1;
            end
            if (scan_ff != tail_ff) begin
               rd_en      = 1'b1;
               rd_addr    = scan_ff;
               scan_in    = ring_next(scan_ff);
               rd_pend_in = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
               if (!rd_pend_ff) begin
                  res_in.pending     = hit_ff;
                  res_in.queue_empty = head_ff == tail_ff;
                  state_in           = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = res_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      kind_ff     <= kind_in;
      req_ff      <= req_in;
      query_ff    <= query_in;
      scan_ff     <= scan_in;
      hit_ff      <= hit_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ sv/crf_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module crf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/crf_match.sv @@
// Fence compare unit: tests one stored descriptor against the sync query.
module crf_match (
   input  crf_pkg::entry_type entry,
   input  crf_pkg::query_type query,
   output logic               hit
);
   import crf_pkg::*;

   logic [RANGE_W-1:0] entry_end;
   logic               below_limit;
   logic               above_base;
   logic               any_range;

   // Range sums are one bit wider than an address, so they never wrap.
   assign entry_end   = {1'b0, entry.dst_addr} + {{(RANGE_W-LEN_W){1'b0}}, entry.length};
   assign below_limit = {1'b0, entry.dst_addr} < query.limit;
   assign above_base  = entry_end > {1'b0, query.base};
   assign any_range   = query.base == '0;

   assign hit = (entry.owner == query.owner) && (any_range || (below_limit && above_base));

endmodule

@@ dv/tb_copy_request_ring_with_fence_top.sv @@
// Self-checking testbench for the copy request ring: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_copy_request_ring_with_fence_top;
   import crf_pkg::*;

   localparam int DEPTH       = RING_DEPTH_DEF;
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_REQS = 1950;
   localparam int CHUNKS      = 10;
   localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
   localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

   typedef struct {
      kind_type kind;
      req_type  req;
      bit       typed;
      rsp_type  want;
   } row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow copy of the descriptor ring.
   logic [ADDR_W-1:0]  ring_src [DEPTH];
   logic [ADDR_W-1:0]  ring_dst [DEPTH];
   logic [LEN_W-1:0]   ring_len [DEPTH];
   logic [OWNER_W-1:0] ring_owner [DEPTH];
   int                 ring_head = 0;
   int                 ring_tail = 0;

   rsp_type            awaited_results [$];
   row_type            plan [$];
   logic [ADDR_W-1:0]  dst_pool [8];
   int                 pool_wr = 0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;
   int mismatches     = 0;
   int results_seen   = 0;
   int kind_count [4];
   int full_rejects   = 0;
   int sync_hits      = 0;
   int fail_completes = 0;
   int empty_completes = 0;

   copy_request_ring_with_fence_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // Works out the result of one request and advances the shadow ring.
   function automatic rsp_type ring_predict(input kind_type k, input req_type r);
      rsp_type            o;
      int                 idx;
      logic [RANGE_W-1:0] q_end;
      logic [RANGE_W-1:0] e_end;
      o = '0;
      kind_count[k]++;
      case (k)
         KIND_SUBMIT: begin
            if ((ring_tail + 1) % DEPTH != ring_head) begin
               ring_src[ring_tail]   = r.src_addr;
               ring_dst[ring_tail]   = r.dst_addr;
               ring_len[ring_tail]   = r.length;
               ring_owner[ring_tail] = r.owner;
               ring_tail  = (ring_tail + 1) % DEPTH;
               o.accepted = 1'b1;
            end else begin
               full_rejects++;
            end
         end
         KIND_PEEK: begin
            if (ring_head != ring_tail) begin
               o.head_src    = ring_src[ring_head];
               o.head_dst    = ring_dst[ring_head];
               o.head_length = ring_len[ring_head];
               o.head_owner  = ring_owner[ring_head];
            end
         end
         KIND_COMPLETE: begin
            if (ring_head != ring_tail) begin
               o.done_status = r.task_ok ? STATUS_OK : STATUS_FAIL;
               if (!r.task_ok) fail_completes++;
               ring_head = (ring_head + 1) % DEPTH;
            end else begin
               empty_completes++;
            end
         end
         default: begin
            // Range ends are formed one bit wider so that they never wrap.
            q_end = {1'b0, r.dst_addr} + RANGE_W'(r.length);
            for (idx = ring_head; idx != ring_tail; idx = (idx + 1) % DEPTH) begin
               e_end = {1'b0, ring_dst[idx]} + RANGE_W'(ring_len[idx]);
               if (ring_owner[idx] == r.owner && (r.dst_addr == '0 ||
                   ({1'b0, ring_dst[idx]} < q_end && e_end > {1'b0, r.dst_addr})))
                  o.pending = 1'b1;
            end
            if (o.pending) sync_hits++;
         end
      endcase
      o.queue_empty = (ring_head == ring_tail);
      return o;
   endfunction

   function automatic rsp_type simple_rsp(input bit acc, input bit empty,
                                          input status_type st, input bit pend);
      rsp_type o;
      o             = '0;
      o.accepted    = acc;
      o.queue_empty = empty;
      o.done_status = st;
      o.pending     = pend;
      return o;
   endfunction

   function automatic void add_row(input kind_type k, input logic [OWNER_W-1:0] own,
                                   input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
                                   input logic [LEN_W-1:0] len, input logic ok,
                                   input bit typed = 1'b0, input rsp_type want = '0);
      row_type row;
      row.kind         = k;
      row.req.owner    = own;
      row.req.src_addr = src;
      row.req.dst_addr = dst;
      row.req.length   = len;
      row.req.task_ok  = ok;
      row.typed        = typed;
      row.want         = want;
      plan.push_back(row);
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      case ($urandom_range(3, 0))
         0:       return wide[ADDR_W-1:0];
         1:       return ADDR_W'($urandom_range(4096, 1));
         2:       return ADDR_MAX - ADDR_W'($urandom_range(4096, 0));
         default: return ADDR_W'(32'h0010_0000 + $urandom_range(65535, 0));
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] rand_len();
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      case ($urandom_range(7, 0))
         0:       return wide[LEN_W-1:0];
         1:       return '0;
         default: return LEN_W'($urandom_range(512, 1));
      endcase
   endfunction

   // Random request; mode 0 leans toward filling the ring, 1 toward draining it.
   function automatic void make_random_request(input int mode, output kind_type k,
                                               output req_type r);
      int          pick;
      int          sub_pct;
      int          peek_pct;
      int          done_pct;
      logic [63:0] wide;
      sub_pct  = (mode == 0) ? 55 : (mode == 1) ? 15 : 30;
      peek_pct = (mode == 0) ? 10 : 15;
      done_pct = (mode == 0) ? 15 : (mode == 1) ? 45 : 25;
      pick     = $urandom_range(99, 0);
      if (pick < sub_pct)                           k = KIND_SUBMIT;
      else if (pick < sub_pct + peek_pct)           k = KIND_PEEK;
      else if (pick < sub_pct + peek_pct + done_pct) k = KIND_COMPLETE;
      else                                          k = KIND_SYNC;
      wide       = {$urandom(), $urandom()};
      r.src_addr = wide[ADDR_W-1:0];
      r.owner    = ($urandom_range(3, 0) == 0) ? OWNER_W'($urandom_range(255, 0))
                                                : OWNER_W'($urandom_range(3, 1));
      r.task_ok  = 1'($urandom_range(1, 0));
      r.length   = rand_len();
      if (k == KIND_SYNC) begin
         // Most queries aim near a recently submitted destination so that overlaps happen.
         case ($urandom_range(7, 0))
            0:       r.dst_addr = '0;
            6, 7:    r.dst_addr = rand_addr();
            default: r.dst_addr = dst_pool[$urandom_range(7, 0)]
                                  + ADDR_W'($urandom_range(600, 0)) - ADDR_W'(300);
         endcase
      end else begin
         r.dst_addr = rand_addr();
         if (k == KIND_SUBMIT) begin
            dst_pool[pool_wr % 8] = r.dst_addr;
            pool_wr++;
         end
      end
   endfunction

   task automatic send_request(input kind_type k, input req_type r,
                               input bit typed, input rsp_type want);
      rsp_type model;
      bit      taken;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {{(REQ_TDATA_W - $bits(req_type)){1'b0}}, r};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      model = ring_predict(k, r);
      awaited_results.push_back(typed ? want : model);
   endtask

   function automatic bit field_differs(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
      if (want !== got) begin
         if (mismatches < 10)
            $display("result %0d, %s: expected 0x%0h, got 0x%0h",
                     results_seen, name, want, got);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic check_result(input logic [RSP_TDATA_W-1:0] raw);
      rsp_type got;
      rsp_type want;
      bit      bad;
      got = raw[$bits(rsp_type)-1:0];
      results_seen++;
      if (awaited_results.size() == 0) begin
         if (mismatches < 10) $display("result %0d arrived with no request waiting on it: 0x%0h",
                                       results_seen, raw);
         mismatches++;
      end else begin
         want = awaited_results.pop_front();
         bad  = 1'b0;
         bad |= field_differs("accepted", 64'(want.accepted), 64'(got.accepted));
         bad |= field_differs("queue_empty", 64'(want.queue_empty), 64'(got.queue_empty));
         bad |= field_differs("head_src", 64'(want.head_src), 64'(got.head_src));
         bad |= field_differs("head_dst", 64'(want.head_dst), 64'(got.head_dst));
         bad |= field_differs("head_length", 64'(want.head_length), 64'(got.head_length));
         bad |= field_differs("head_owner", 64'(want.head_owner), 64'(got.head_owner));
         bad |= field_differs("done_status", 64'(want.done_status), 64'(got.done_status));
         bad |= field_differs("pending", 64'(want.pending), 64'(got.pending));
         bad |= field_differs("padding", 64'(0), 64'(raw[RSP_TDATA_W-1:$bits(rsp_type)]));
         if (bad) mismatches++;
      end
   endtask

   // Handshakes are sampled on the falling edge ahead of the rising edge that completes them.
   always @(negedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no request or result moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
      end
   end

   initial begin
      rsp_type  want;
      kind_type k;
      req_type  r;
      int       chunk;
      int       n;
      int       idx;

      foreach (kind_count[i]) kind_count[i] = 0;
      foreach (dst_pool[i]) dst_pool[i] = '0;

      add_row(KIND_PEEK,     8'd0,   '0, '0, '0, 1'b0, 1'b1, simple_rsp(0, 1, STATUS_NONE, 0));
      add_row(KIND_COMPLETE, 8'd0,   '0, '0, '0, 1'b1, 1'b1, simple_rsp(0, 1, STATUS_NONE, 0));
      add_row(KIND_SYNC,     8'd0,   '0, '0, '0, 1'b0, 1'b1, simple_rsp(0, 1, STATUS_NONE, 0));
      add_row(KIND_SUBMIT,   8'd255, ADDR_MAX, ADDR_MAX, LEN_MAX, 1'b1,
              1'b1, simple_rsp(1, 0, STATUS_NONE, 0));
      want             = simple_rsp(0, 0, STATUS_NONE, 0);
      want.head_src    = ADDR_MAX;
      want.head_dst    = ADDR_MAX;
      want.head_length = LEN_MAX;
      want.head_owner  = 8'd255;
      add_row(KIND_PEEK,     8'd0,   '0, '0, '0, 1'b0, 1'b1, want);
      // A zero base matches any entry of the owner; a zero-length query at the entry's own start does not.
      add_row(KIND_SYNC,     8'd255, '0, '0, '0, 1'b0, 1'b1, simple_rsp(0, 0, STATUS_NONE, 1));
      add_row(KIND_SYNC,     8'd255, '0, ADDR_MAX, '0, 1'b0,
              1'b1, simple_rsp(0, 0, STATUS_NONE, 0));
      add_row(KIND_SYNC,     8'd254, '0, '0, '0, 1'b0, 1'b1, simple_rsp(0, 0, STATUS_NONE, 0));
      add_row(KIND_SYNC,     8'd255, '0, ADDR_MAX, LEN_MAX, 1'b0);
      add_row(KIND_SUBMIT,   8'd0,   '0, '0, '0, 1'b0);
      add_row(KIND_SUBMIT,   8'd1,   39'h55_5555_5555, 39'h1000, 31'h100, 1'b0);
      add_row(KIND_SUBMIT,   8'd1,   39'h2a_aaaa_aaaa, 39'h2000, 31'h1, 1'b1);
      add_row(KIND_SUBMIT,   8'd128, 39'h12_3456_789a, 39'h40_0000_0000, 31'h4000_0000, 1'b0);
      add_row(KIND_SUBMIT,   8'd1,   39'h7, 39'h3000, 31'h10, 1'b1);
      add_row(KIND_SUBMIT,   8'd2,   39'h7f_0000_0001, 39'h1080, 31'h80, 1'b0);
      // Seven entries are pending now, so the ring is full.
      add_row(KIND_SUBMIT,   8'd3,   39'h1, 39'h1, 31'h1, 1'b1,
              1'b1, simple_rsp(0, 0, STATUS_NONE, 0));
      add_row(KIND_SYNC,     8'd1,   '0, 39'h10ff, 31'h1, 1'b0);
      add_row(KIND_SYNC,     8'd1,   '0, 39'h1100, 31'h1000, 1'b0);
      add_row(KIND_SYNC,     8'd0,   '0, 39'h1, LEN_MAX, 1'b0);
      add_row(KIND_COMPLETE, 8'd0,   '0, '0, '0, 1'b1, 1'b1, simple_rsp(0, 0, STATUS_OK, 0));
      add_row(KIND_COMPLETE, 8'd0,   '0, '0, '0, 1'b0, 1'b1, simple_rsp(0, 0, STATUS_FAIL, 0));
      add_row(KIND_PEEK,     8'd0,   '0, '0, '0, 1'b0);
      add_row(KIND_COMPLETE, 8'd0,   '0, '0, '0, 1'b1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_request(plan[i].kind, plan[i].req, plan[i].typed, plan[i].want);

      for (chunk = 0; chunk < CHUNKS; chunk++) begin
         // Hold off until the ring has answered everything sent so far.
         req_tvalid <= 1'b0;
         do @(posedge clock); while (awaited_results.size() != 0);
         case (chunk % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         for (n = 0; n < RANDOM_REQS / CHUNKS; n++) begin
            idx = chunk * (RANDOM_REQS / CHUNKS) + n;
            make_random_request((idx / 30) % 3, k, r);
            send_request(k, r, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
      repeat (2 * (DEPTH + 4)) @(posedge clock);
      mismatches += awaited_results.size();

      $display("Sent %0d submits (%0d turned away on a full ring), %0d peeks, %0d syncs",
               kind_count[KIND_SUBMIT], full_rejects, kind_count[KIND_PEEK],
               kind_count[KIND_SYNC]);
      $display("  with %0d overlap hits, %0d completes (%0d failed, %0d on an empty ring).",
               sync_hits, kind_count[KIND_COMPLETE], fail_completes, empty_completes);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d results were wrong", mismatches);
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ copy_request_ring_with_fence_top.f @@
sv/crf_pkg.sv
sv/crf_ram.sv
sv/crf_match.sv
sv/copy_request_ring_with_fence_top.sv
dv/tb_copy_request_ring_with_fence_top.sv
